FILE: rtl/ifsp_pkg.sv
package ifsp_pkg;

  localparam logic [7:0] PREAMBLE_BYTE = 8'hFA;
  localparam logic [7:0] MAX_LENGTH    = 8'hFE;

  localparam logic [7:0] BUS_ID_RESET = 8'hFF;
  localparam logic [7:0] MSG_ID_RESET = 8'h32;

  // Configuration register indexes
  localparam logic [1:0] REG_BUS_ID = 2'd0;
  localparam logic [1:0] REG_MSG_ID = 2'd1;

  // Result kinds
  localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
  localparam logic [1:0] KIND_GOOD_SUM  = 2'd1;
  localparam logic [1:0] KIND_BAD_SUM   = 2'd2;

  typedef enum logic [5:0] {
    PH_HUNT    = 6'b000001,
    PH_BUS     = 6'b000010,
    PH_MSG     = 6'b000100,
    PH_LEN     = 6'b001000,
    PH_PAYLOAD = 6'b010000,
    PH_CHECK   = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [7:0] index;
    logic [7:0] length;
    logic       last;
  } result_t;

  // Handshake between the input stage, the parser and the output stage
  typedef struct packed {
    logic proc;  // parser consumes the held item this cycle
    logic adv;   // output register may load this cycle
  } flow_t;

endpackage

FILE: rtl/imu_serial_frame_parser.sv
// A byte is held in the input register, its result in the output register.
// One byte per cycle unless stalled; the parser state updates once per byte.
// Stalls on the output side back up through the input register.
// Reset (rst, synchronous, active high): parser hunts for a preamble,
// both channels empty, bus id 0xFF and message id 0x32.
module imu_serial_frame_parser
  import ifsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // receive byte channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] result_kind,
  output logic [7:0] out_byte,
  output logic [7:0] byte_index,
  output logic [7:0] frame_length,
  output logic       last_payload,
  // configuration writes
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic       held_vld;
  logic [7:0] held_byte;
  logic [7:0] bus_id;
  logic [7:0] msg_id;
  logic       res_vld;
  result_t    res;
  result_t    out_res;
  flow_t      flow;
  logic       adv;

  // Config registers: always ready, writes to unused indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_id <= BUS_ID_RESET;
      msg_id <= MSG_ID_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BUS_ID: bus_id <= cfg_data;
        REG_MSG_ID: msg_id <= cfg_data;
        default:    ;
      endcase
    end
  end

  // The held item is parsed only when the output register can take its
  // result, so the parser state never runs ahead of delivered items.
  assign flow.adv  = adv;
  assign flow.proc = held_vld & adv;

  ifsp_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .rx_byte   (rx_byte),
    .flow      (flow),
    .in_stall  (in_stall),
    .held_vld  (held_vld),
    .held_byte (held_byte)
  );

  ifsp_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .proc    (flow.proc),
    .b       (held_byte),
    .bus_id  (bus_id),
    .msg_id  (msg_id),
    .res_vld (res_vld),
    .res     (res)
  );

  ifsp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .proc      (flow.proc),
    .res_vld   (res_vld),
    .res       (res),
    .out_stall (out_stall),
    .adv       (adv),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign result_kind  = out_res.kind;
  assign out_byte     = out_res.data;
  assign byte_index   = out_res.index;
  assign frame_length = out_res.length;
  assign last_payload = out_res.last;

endmodule

FILE: rtl/ifsp_in_stage.sv
module ifsp_in_stage
  import ifsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] rx_byte,
  input  flow_t      flow,
  output logic       in_stall,
  output logic       held_vld,
  output logic [7:0] held_byte
);

  logic accept;

  assign in_stall = held_vld & ~flow.adv;
  assign accept   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_vld <= 1'b0;
    end else if (accept) begin
      held_vld <= 1'b1;
    end else if (flow.proc) begin
      held_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_byte <= rx_byte;
    end
  end

endmodule

FILE: rtl/ifsp_parse.sv
module ifsp_parse
  import ifsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       proc,
  input  logic [7:0] b,
  input  logic [7:0] bus_id,
  input  logic [7:0] msg_id,
  output logic       res_vld,
  output result_t    res
);

  phase_t     phase, phase_next;
  logic [7:0] sum, sum_next;
  logic [7:0] len, len_next;
  logic [7:0] cnt, cnt_next;
  logic [7:0] cnt_inc;
  logic [7:0] chk;
  logic       last;

  assign cnt_inc = cnt + 8'd1;
  assign last    = (cnt_inc >= len);
  assign chk     = sum + b;

  always_comb begin
    phase_next = PH_HUNT;
    sum_next   = 8'd0;
    len_next   = 8'd0;
    cnt_next   = 8'd0;
    res_vld    = 1'b0;
    res        = '0;
    res.data   = b;
    res.length = len;
    case (phase)
      PH_HUNT: begin
        if (b == PREAMBLE_BYTE) begin
          phase_next = PH_BUS;
        end
      end
      PH_BUS: begin
        if (b == bus_id) begin
          phase_next = PH_MSG;
          sum_next   = sum + b;
        end
      end
      PH_MSG: begin
        if (b == msg_id) begin
          phase_next = PH_LEN;
          sum_next   = sum + b;
        end
      end
      PH_LEN: begin
        if (b <= MAX_LENGTH) begin
          // empty frame goes straight to the checksum
          phase_next = (b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
          sum_next   = sum + b;
          len_next   = b;
        end
      end
      PH_PAYLOAD: begin
        phase_next = last ? PH_CHECK : PH_PAYLOAD;
        sum_next   = sum + b;
        len_next   = len;
        cnt_next   = cnt_inc;
        res_vld    = 1'b1;
        res.kind   = KIND_PAYLOAD;
        res.index  = cnt;
        res.last   = last;
      end
      PH_CHECK: begin
        res_vld  = 1'b1;
        res.kind = (chk == 8'd0) ? KIND_GOOD_SUM : KIND_BAD_SUM;
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      sum   <= 8'd0;
      len   <= 8'd0;
      cnt   <= 8'd0;
    end else if (proc) begin
      phase <= phase_next;
      sum   <= sum_next;
      len   <= len_next;
      cnt   <= cnt_next;
    end
  end

endmodule

FILE: rtl/ifsp_out_stage.sv
module ifsp_out_stage
  import ifsp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    proc,
  input  logic    res_vld,
  input  result_t res,
  input  logic    out_stall,
  output logic    adv,
  output logic    out_valid,
  output result_t out_res
);

  // register may load when empty or when its item leaves this cycle
  assign adv = ~out_valid | ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= proc & res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && proc && res_vld) begin
      out_res <= res;
    end
  end

endmodule
